/* design/wpl_pkg.sv */
`timescale 1ns / 1ps

package wpl_pkg;

   // channel and register widths
   localparam int WHEELS    = 4;
   localparam int CMD_W     = 16;
   localparam int SPD_W     = 16;
   localparam int CAP_W     = 16;
   localparam int COEF_W    = 32;
   localparam int SP_W      = 16;
   localparam int LIM_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // datapath widths
   localparam int FRAC_W = 40;                  // coefficient scale 2^-40
   localparam int PROD_W = 64;                  // coefficient times square
   localparam int SUM_W  = PROD_W + 2;          // three products summed
   localparam int EST_W  = SUM_W - FRAC_W;      // per-wheel power estimate
   localparam int TOT_W  = EST_W + 2;           // sum of four estimates
   localparam int NUM_W  = EST_W - 1 + CAP_W;   // estimate times cap
   localparam int QUO_W  = 16;                  // scaled power
   localparam int TS_W   = COEF_W + SPD_W + 1;  // torque_coef * speed, either sign
   localparam int C0_W   = 64;                  // constant term of the quadratic
   localparam int SRCH_W = QUO_W;               // search offset from the low bound

   // pipeline depth
   localparam int DIV_STEPS  = QUO_W;
   localparam int SRCH_STEPS = SRCH_W;
   localparam int PRE_STG    = 4;
   localparam int DIV_LAST   = PRE_STG + DIV_STEPS - 1;
   localparam int NSTG       = PRE_STG + DIV_STEPS + 1 + 2 * SRCH_STEPS + 1;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TORQUE = 3'd0,
      CSR_CUR_SQ = 3'd1,
      CSR_SPD_SQ = 3'd2,
      CSR_STATIC = 3'd3,
      CSR_LIMIT  = 3'd4
   } csr_idx_type;

   // one wheel handed to the root search
   typedef struct packed {
      logic                     recompute;
      logic                     upper;
      logic signed [CMD_W-1:0]  cmd;
      logic signed [TS_W-1:0]   tse;
      logic signed [C0_W-1:0]   c0;
   } srch_req_type;

endpackage

/* design/wheel_power_limiter_unit.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle while the result is not stalled; the
// estimate, the 16-step divider and the 16-step root search (two stages
// per step) are all fully pipelined.
// A stalled result freezes every stage; no request is dropped or repeated.
// Reset clears all valid bits and restores the coefficient registers to defaults.

module wheel_power_limiter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wpl_pkg::CMD_W-1:0]    req_cmd_0,
   input  logic signed [wpl_pkg::CMD_W-1:0]    req_cmd_1,
   input  logic signed [wpl_pkg::CMD_W-1:0]    req_cmd_2,
   input  logic signed [wpl_pkg::CMD_W-1:0]    req_cmd_3,
   input  logic signed [wpl_pkg::SPD_W-1:0]    req_speed_0,
   input  logic signed [wpl_pkg::SPD_W-1:0]    req_speed_1,
   input  logic signed [wpl_pkg::SPD_W-1:0]    req_speed_2,
   input  logic signed [wpl_pkg::SPD_W-1:0]    req_speed_3,
   input  logic [wpl_pkg::CAP_W-1:0]           req_power_cap,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [wpl_pkg::CMD_W-1:0]    rsp_out_0,
   output logic signed [wpl_pkg::CMD_W-1:0]    rsp_out_1,
   output logic signed [wpl_pkg::CMD_W-1:0]    rsp_out_2,
   output logic signed [wpl_pkg::CMD_W-1:0]    rsp_out_3,
   output logic                                rsp_limited,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wpl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wpl_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import wpl_pkg::*;

   // configuration
   logic [COEF_W-1:0]  torque_ff;
   logic [COEF_W-1:0]  cur_sq_ff;
   logic [COEF_W-1:0]  spd_sq_ff;
   logic [SP_W-1:0]    static_ff;
   logic [LIM_W-1:0]   limit_ff;

   logic               advance;
   logic               vld_ff [NSTG];

   logic signed [CMD_W-1:0]  c_in [WHEELS];
   logic signed [SPD_W-1:0]  s_in [WHEELS];
   logic signed [31:0]       cc_c [WHEELS];
   logic signed [31:0]       cs_c [WHEELS];
   logic signed [31:0]       ss_c [WHEELS];
   logic signed [TS_W-1:0]   ts_c [WHEELS];

   // stage 1: small products
   logic [31:0]              cc1_ff [WHEELS];
   logic signed [31:0]       cs1_ff [WHEELS];
   logic [31:0]              ss1_ff [WHEELS];
   logic signed [TS_W-1:0]   ts1_ff [WHEELS];
   logic signed [CMD_W-1:0]  c1_ff  [WHEELS];
   logic [CAP_W-1:0]         cap1_ff;

   // stage 2: coefficient products
   logic [PROD_W-1:0]        acc2_ff [WHEELS];
   logic signed [PROD_W-1:0] tcs2_ff [WHEELS];
   logic [PROD_W-1:0]        kss2_ff [WHEELS];
   logic signed [TS_W-1:0]   ts2_ff  [WHEELS];
   logic signed [CMD_W-1:0]  c2_ff   [WHEELS];
   logic [CAP_W-1:0]         cap2_ff;

   // stage 3: estimates
   logic signed [SUM_W-1:0]  sum_c  [WHEELS];
   logic signed [EST_W-1:0]  e3_ff  [WHEELS];
   logic [PROD_W-1:0]        kss3_ff [WHEELS];
   logic signed [TS_W-1:0]   ts3_ff [WHEELS];
   logic signed [CMD_W-1:0]  c3_ff  [WHEELS];
   logic [CAP_W-1:0]         cap3_ff;

   // stage 4: total and dividends
   logic [TOT_W-1:0]         tot_c;
   logic [TOT_W-1:0]         tot4_ff;
   logic                     lim4_ff;
   logic [NUM_W-1:0]         num4_ff  [WHEELS];
   logic                     eneg4_ff [WHEELS];
   logic [PROD_W-1:0]        kss4_ff  [WHEELS];
   logic signed [TS_W-1:0]   ts4_ff   [WHEELS];
   logic signed [CMD_W-1:0]  c4_ff    [WHEELS];

   // divider, one quotient bit per stage
   logic [TOT_W-1:0]         rem_ff   [DIV_STEPS][WHEELS];
   logic [QUO_W-1:0]         quo_ff   [DIV_STEPS][WHEELS];
   logic [QUO_W-1:0]         lo_ff    [DIV_STEPS][WHEELS];
   logic [TOT_W-1:0]         dtot_ff  [DIV_STEPS];
   logic                     dlim_ff  [DIV_STEPS];
   logic                     deneg_ff [DIV_STEPS][WHEELS];
   logic [PROD_W-1:0]        dkss_ff  [DIV_STEPS][WHEELS];
   logic signed [TS_W-1:0]   dts_ff   [DIV_STEPS][WHEELS];
   logic signed [CMD_W-1:0]  dc_ff    [DIV_STEPS][WHEELS];

   logic [TOT_W-1:0]         rem_in   [DIV_STEPS][WHEELS];
   logic [QUO_W-1:0]         quo_in   [DIV_STEPS][WHEELS];
   logic [QUO_W-1:0]         lo_src   [DIV_STEPS][WHEELS];

   // prep stage and search
   srch_req_type             srch_in  [WHEELS];
   srch_req_type             srch5_ff [WHEELS];
   logic                     lim5_ff;
   logic                     slim_ff  [2*SRCH_STEPS];
   logic signed [CMD_W-1:0]  srch_out [WHEELS];
   logic signed [C0_W-1:0]   d_c      [WHEELS];

   // result register
   logic signed [CMD_W-1:0]  out_ff [WHEELS];
   logic                     olim_ff;

   assign advance   = !(vld_ff[NSTG-1] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   assign c_in[0] = req_cmd_0;
   assign c_in[1] = req_cmd_1;
   assign c_in[2] = req_cmd_2;
   assign c_in[3] = req_cmd_3;
   assign s_in[0] = req_speed_0;
   assign s_in[1] = req_speed_1;
   assign s_in[2] = req_speed_2;
   assign s_in[3] = req_speed_3;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         torque_ff <= COEF_W'(2195575);
         cur_sq_ff <= COEF_W'(135240);
         spd_sq_ff <= COEF_W'(159760);
         static_ff <= SP_W'(261);
         limit_ff  <= LIM_W'(12000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TORQUE: torque_ff <= csr_wdata[COEF_W-1:0];
            CSR_CUR_SQ: cur_sq_ff <= csr_wdata[COEF_W-1:0];
            CSR_SPD_SQ: spd_sq_ff <= csr_wdata[COEF_W-1:0];
            CSR_STATIC: static_ff <= csr_wdata[SP_W-1:0];
            CSR_LIMIT:  limit_ff  <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NSTG; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // estimate arithmetic, total and divider steps
   always_comb begin
      tot_c = '0;
      for (int w = 0; w < WHEELS; w++) begin
         cc_c[w]  = c_in[w] * c_in[w];
         cs_c[w]  = c_in[w] * s_in[w];
         ss_c[w]  = s_in[w] * s_in[w];
         ts_c[w]  = signed'({1'b0, torque_ff}) * s_in[w];
         sum_c[w] = signed'({2'b0, acc2_ff[w]}) + SUM_W'(tcs2_ff[w])
                    + signed'({2'b0, kss2_ff[w]});
         if (!e3_ff[w][EST_W-1]) tot_c = tot_c + TOT_W'(e3_ff[w][EST_W-2:0]);
      end
   end

   always_comb begin
      logic [TOT_W:0]   sh;
      logic [TOT_W-1:0] rsrc;
      logic [QUO_W-1:0] qsrc;
      for (int j = 0; j < DIV_STEPS; j++) begin
         for (int w = 0; w < WHEELS; w++) begin
            if (j == 0) begin
               rsrc         = TOT_W'(num4_ff[w][NUM_W-1:QUO_W]);
               qsrc         = '0;
               lo_src[j][w] = num4_ff[w][QUO_W-1:0];
               sh           = {rsrc, lo_src[j][w][QUO_W-1-j]};
               if (sh >= {1'b0, tot4_ff}) begin
                  sh           = sh - {1'b0, tot4_ff};
                  quo_in[j][w] = {qsrc[QUO_W-2:0], 1'b1};
               end else begin
                  quo_in[j][w] = {qsrc[QUO_W-2:0], 1'b0};
               end
            end else begin
               rsrc         = rem_ff[j-1][w];
               qsrc         = quo_ff[j-1][w];
               lo_src[j][w] = lo_ff[j-1][w];
               sh           = {rsrc, lo_src[j][w][QUO_W-1-j]};
               if (sh >= {1'b0, dtot_ff[j-1]}) begin
                  sh           = sh - {1'b0, dtot_ff[j-1]};
                  quo_in[j][w] = {qsrc[QUO_W-2:0], 1'b1};
               end else begin
                  quo_in[j][w] = {qsrc[QUO_W-2:0], 1'b0};
               end
            end
            rem_in[j][w] = sh[TOT_W-1:0];
         end
      end
   end

   // build the search request: sign side, mirrored slope, constant term
   always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
         d_c[w] = C0_W'(signed'({2'b0, static_ff}) -
                        signed'({2'b0, quo_ff[DIV_STEPS-1][w]}));
         srch_in[w].recompute = dlim_ff[DIV_STEPS-1] && !deneg_ff[DIV_STEPS-1][w];
         srch_in[w].upper = !dc_ff[DIV_STEPS-1][w][CMD_W-1] &&
                            (dc_ff[DIV_STEPS-1][w] != '0);
         srch_in[w].cmd   = dc_ff[DIV_STEPS-1][w];
         srch_in[w].tse   = srch_in[w].upper ? dts_ff[DIV_STEPS-1][w]
                                             : -dts_ff[DIV_STEPS-1][w];
         srch_in[w].c0    = signed'(dkss_ff[DIV_STEPS-1][w]) + (d_c[w] <<< FRAC_W);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         cap1_ff <= req_power_cap;
         cap2_ff <= cap1_ff;
         cap3_ff <= cap2_ff;
         tot4_ff <= tot_c;
         lim4_ff <= (tot_c > TOT_W'(cap3_ff));
         for (int w = 0; w < WHEELS; w++) begin
            cc1_ff[w]   <= cc_c[w];
            cs1_ff[w]   <= cs_c[w];
            ss1_ff[w]   <= ss_c[w];
            ts1_ff[w]   <= ts_c[w];
            c1_ff[w]    <= c_in[w];
            acc2_ff[w]  <= cur_sq_ff * cc1_ff[w];
            tcs2_ff[w]  <= signed'({1'b0, torque_ff}) * cs1_ff[w];
            kss2_ff[w]  <= spd_sq_ff * ss1_ff[w];
            ts2_ff[w]   <= ts1_ff[w];
            c2_ff[w]    <= c1_ff[w];
            e3_ff[w]    <= signed'(sum_c[w][SUM_W-1:FRAC_W])
                           + signed'({{(EST_W-SP_W){1'b0}}, static_ff});
            kss3_ff[w]  <= kss2_ff[w];
            ts3_ff[w]   <= ts2_ff[w];
            c3_ff[w]    <= c2_ff[w];
            num4_ff[w]  <= e3_ff[w][EST_W-1] ? '0 : e3_ff[w][EST_W-2:0] * cap3_ff;
            eneg4_ff[w] <= e3_ff[w][EST_W-1];
            kss4_ff[w]  <= kss3_ff[w];
            ts4_ff[w]   <= ts3_ff[w];
            c4_ff[w]    <= c3_ff[w];
         end
         dtot_ff[0]  <= tot4_ff;
         dlim_ff[0]  <= lim4_ff;
         deneg_ff[0] <= eneg4_ff;
         dkss_ff[0]  <= kss4_ff;
         dts_ff[0]   <= ts4_ff;
         dc_ff[0]    <= c4_ff;
         for (int j = 1; j < DIV_STEPS; j++) begin
            dtot_ff[j]  <= dtot_ff[j-1];
            dlim_ff[j]  <= dlim_ff[j-1];
            deneg_ff[j] <= deneg_ff[j-1];
            dkss_ff[j]  <= dkss_ff[j-1];
            dts_ff[j]   <= dts_ff[j-1];
            dc_ff[j]    <= dc_ff[j-1];
         end
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         lo_ff  <= lo_src;
         srch5_ff   <= srch_in;
         lim5_ff    <= dlim_ff[DIV_STEPS-1];
         slim_ff[0] <= lim5_ff;
         for (int i = 1; i < 2 * SRCH_STEPS; i++) slim_ff[i] <= slim_ff[i-1];
         out_ff  <= srch_out;
         olim_ff <= slim_ff[2*SRCH_STEPS-1];
      end
   end

   // root search per wheel
   for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
      wpl_root_search u_search (
         .clock   (clock),
         .advance (advance),
         .sq_coef (cur_sq_ff),
         .cmd_lim (limit_ff),
         .req     (srch5_ff[w]),
         .cmd_out (srch_out[w])
      );
   end

   assign rsp_valid   = vld_ff[NSTG-1];
   assign rsp_out_0   = out_ff[0];
   assign rsp_out_1   = out_ff[1];
   assign rsp_out_2   = out_ff[2];
   assign rsp_out_3   = out_ff[3];
   assign rsp_limited = olim_ff;

`ifndef SYNTH
   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an accepted request enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request lost at entry");

   // input is held back only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output stall");

   // wheel 0 divider remainder stays below the total when scaling
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DIV_LAST] && dlim_ff[DIV_STEPS-1]) |->
      (rem_ff[DIV_STEPS-1][0] < dtot_ff[DIV_STEPS-1]))
      else $error("divider remainder out of range");
`endif

endmodule

/* design/wpl_root_search.sv */
`timescale 1ns / 1ps

module wpl_root_search (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [wpl_pkg::COEF_W-1:0]         sq_coef,
   input  logic [wpl_pkg::LIM_W-1:0]          cmd_lim,
   input  wpl_pkg::srch_req_type              req,
   output logic signed [wpl_pkg::CMD_W-1:0]   cmd_out
);
   import wpl_pkg::*;

   localparam int X_W   = SRCH_W + 2;
   localparam int XX_W  = 2 * SRCH_W;
   localparam int TSX_W = TS_W + X_W;
   localparam int G_W   = COEF_W + X_W + 3;
   localparam int F_W   = TSX_W + 2;

   // first half of a step: candidate and its products
   srch_req_type                a_req_ff  [SRCH_STEPS];
   logic [SRCH_W-1:0]           a_k_ff    [SRCH_STEPS];
   logic [SRCH_W-1:0]           a_cand_ff [SRCH_STEPS];
   logic                        a_rng_ff  [SRCH_STEPS];
   logic [XX_W-1:0]             a_xx_ff   [SRCH_STEPS];
   logic signed [TSX_W-1:0]     a_tsx_ff  [SRCH_STEPS];
   logic signed [G_W-1:0]       a_g_ff    [SRCH_STEPS];

   // second half: decision
   srch_req_type                b_req_ff  [SRCH_STEPS];
   logic [SRCH_W-1:0]           b_k_ff    [SRCH_STEPS];

   srch_req_type                src_req   [SRCH_STEPS];
   logic [SRCH_W-1:0]           src_k     [SRCH_STEPS];
   logic [SRCH_W-1:0]           cand_c    [SRCH_STEPS];
   logic signed [X_W-1:0]       x_c       [SRCH_STEPS];
   logic signed [2*X_W-1:0]     xsq_c     [SRCH_STEPS];
   logic signed [TSX_W-1:0]     tsx_c     [SRCH_STEPS];
   logic signed [G_W-1:0]       g_c       [SRCH_STEPS];
   logic [2*COEF_W-1:0]         axx_c     [SRCH_STEPS];
   logic signed [F_W-1:0]       f_c       [SRCH_STEPS];
   logic                        ok_c      [SRCH_STEPS];
   logic [SRCH_W-1:0]           lim2;
   logic signed [X_W-1:0]       xr;
   logic signed [X_W-1:0]       r;

   assign lim2 = {cmd_lim, 1'b0};

   // try setting one offset bit per step, most significant first
   always_comb begin
      for (int i = 0; i < SRCH_STEPS; i++) begin
         if (i == 0) begin
            src_req[i] = req;
            src_k[i]   = '0;
         end else begin
            src_req[i] = b_req_ff[i-1];
            src_k[i]   = b_k_ff[i-1];
         end
         cand_c[i] = src_k[i] | (SRCH_W'(1) << (SRCH_W - 1 - i));
         x_c[i]    = signed'({2'b0, cand_c[i]}) - signed'({3'b0, cmd_lim});
         xsq_c[i]  = x_c[i] * x_c[i];
         tsx_c[i]  = src_req[i].tse * x_c[i];
         g_c[i]    = signed'({2'b0, sq_coef, 1'b0}) * x_c[i] + src_req[i].tse;
         axx_c[i]  = sq_coef * a_xx_ff[i];
         f_c[i]    = F_W'(axx_c[i]) + F_W'(a_tsx_ff[i]) + F_W'(a_req_ff[i].c0);
         ok_c[i]   = a_rng_ff[i] &&
                     (a_g_ff[i][G_W-1] || (a_g_ff[i] == '0) ||
                      f_c[i][F_W-1] || (f_c[i] == '0));
      end
   end

   // advance both halves of every step
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < SRCH_STEPS; i++) begin
            a_req_ff[i]  <= src_req[i];
            a_k_ff[i]    <= src_k[i];
            a_cand_ff[i] <= cand_c[i];
            a_rng_ff[i]  <= (cand_c[i] <= lim2);
            a_xx_ff[i]   <= xsq_c[i][XX_W-1:0];
            a_tsx_ff[i]  <= tsx_c[i];
            a_g_ff[i]    <= g_c[i];
            b_req_ff[i]  <= a_req_ff[i];
            b_k_ff[i]    <= ok_c[i] ? a_cand_ff[i] : a_k_ff[i];
         end
      end
   end

   // map the offset back to a command, mirrored for the negative side; unscaled wheels keep their command
   assign xr = signed'({2'b0, b_k_ff[SRCH_STEPS-1]}) - signed'({3'b0, cmd_lim});
   assign r  = b_req_ff[SRCH_STEPS-1].upper ? xr : -xr;
   assign cmd_out = b_req_ff[SRCH_STEPS-1].recompute ? r[CMD_W-1:0]
                                                     : b_req_ff[SRCH_STEPS-1].cmd;

endmodule
